// File: rtl/r2fft_pkg.sv
// Shared constants and the twiddle generator for the radix-2 FFT.
package r2fft_pkg;

  // Twiddle format: Q1.17, which needs 19 signed bits to hold +1.0.
  localparam int TwFrac = 17;
  localparam int TwW    = 19;

  // One part of W^k, rounded half up to Q1.17; unit is 2*pi/POINTS, quarter is POINTS/4.
  function automatic int twiddle(real unit, int quarter, int k, bit imag);
    real ang;
    real cv;
    real sv;
    int  m;
    int  ci;
    int  si;
    begin
      m   = (k < quarter) ? k : k - quarter;
      ang = unit * m;
      cv  = $cos(ang) * 131072.0;
      sv  = $sin(ang) * 131072.0;
      ci  = $rtoi($floor(cv + 0.5));
      si  = $rtoi($floor(sv + 0.5));
      if (ci < 0) ci = 0;
      if (si < 0) si = 0;
      if (k < quarter) begin
        twiddle = imag ? -si : ci;
      end else begin
        twiddle = imag ? -ci : -si;
      end
    end
  endfunction

endpackage

// File: rtl/r2fft_ram.sv
// Generic RAM with one write port and two registered read ports.
module r2fft_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

// File: rtl/r2fft_fifo.sv
// Small item queue used on the command and result sides.
module r2fft_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = data_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    if (do_pop)  rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    cnt_d = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) data_q[wptr_q] <= wdata_i;
  end

endmodule

// File: rtl/r2fft_core.sv
// Back end: frame store, butterfly sequencer and bin readout.
module r2fft_core #(
  parameter int POINTS      = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cmd_valid_i,
  input  logic                                   cmd_i,
  input  logic signed [SAMPLE_BITS-1:0]          re_i,
  input  logic signed [SAMPLE_BITS-1:0]          im_i,
  output logic                                   cmd_pop_o,
  input  logic                                   res_full_i,
  output logic                                   res_push_o,
  output logic signed [SAMPLE_BITS+$clog2(POINTS)+1:0] res_re_o,
  output logic signed [SAMPLE_BITS+$clog2(POINTS)+1:0] res_im_o,
  output logic [$clog2(POINTS)-1:0]              res_index_o,
  output logic                                   res_last_o,
  output logic                                   res_ready_o
);
  import r2fft_pkg::*;

  localparam int  Log    = $clog2(POINTS);
  localparam int  BinW   = SAMPLE_BITS + Log + 2;
  localparam int  Half   = POINTS / 2;
  localparam int  Quart  = POINTS / 4;
  localparam int  StgW   = (Log > 2) ? $clog2(Log) : 1;
  localparam int  ProdW  = BinW + TwW;
  localparam int  RndW   = ProdW + 1 - TwFrac;
  localparam int  SumW   = RndW + 1;
  localparam real Unit   = 2.0 * 3.14159265358979323846 / POINTS;
  localparam logic signed [SumW-1:0] Lim = SumW'(1) <<< (SAMPLE_BITS + Log);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_BF_RD, ST_BF_MUL, ST_BF_ADD, ST_BF_WA, ST_BF_WB
  } state_e;

  state_e              state_q;
  logic [Log-1:0]      load_cnt_q, read_cnt_q;
  logic                done_q;
  logic [StgW-1:0]     stage_q;
  logic [Log-2:0]      bf_q;
  logic signed [ProdW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [BinW-1:0]  ur_q, ui_q;
  logic [2*BinW-1:0]   a_val_q, b_val_q;

  logic                we;
  logic [Log-1:0]      waddr, raddr0, raddr1, rev_addr, addr_a, addr_b;
  logic [2*BinW-1:0]   wdata, rdata0, rdata1;
  logic [Log-2:0]      j_idx, tw_k, mask;
  logic signed [TwW-1:0] rom_re [Half];
  logic signed [TwW-1:0] rom_im [Half];
  logic signed [TwW-1:0] wr, wi;
  logic signed [BinW-1:0] vr, vi;
  logic signed [ProdW:0]  sum_r, sum_i;
  logic signed [RndW-1:0] tr, ti;
  logic                last_bf;

  // Twiddle table, fixed at elaboration.
  for (genvar g = 0; g < Half; g++) begin : g_rom
    assign rom_re[g] = TwW'(twiddle(Unit, Quart, g, 1'b0));
    assign rom_im[g] = TwW'(twiddle(Unit, Quart, g, 1'b1));
  end

  function automatic logic signed [BinW-1:0] sat_fn(logic signed [SumW-1:0] v);
    if (v > Lim)       sat_fn = BinW'(Lim);
    else if (v < -Lim) sat_fn = BinW'(-Lim);
    else               sat_fn = BinW'(v);
  endfunction

  // Loads land at the bit-reversed address, which replaces the permutation pass.
  always_comb begin
    for (int b = 0; b < Log; b++) rev_addr[b] = load_cnt_q[Log-1-b];
  end

  // Butterfly addresses: insert a zero at the stage bit to get the upper leg.
  always_comb begin
    mask   = (Log-1)'(((Log)'(1) << stage_q) - 1'b1);
    j_idx  = bf_q & mask;
    addr_a = (Log'(bf_q >> stage_q) << (stage_q + 1'b1)) | Log'(j_idx);
    addr_b = addr_a | (Log'(1) << stage_q);
    tw_k   = j_idx << ((Log - 1) - int'(stage_q));
    wr     = rom_re[tw_k];
    wi     = rom_im[tw_k];
    last_bf = (bf_q == (Log-1)'(Half - 1));
  end

  // Product rounding, half up.
  always_comb begin
    sum_r = (ProdW+1)'(p_rr_q) - (ProdW+1)'(p_ii_q) + (ProdW+1)'(1 <<< (TwFrac - 1));
    sum_i = (ProdW+1)'(p_ri_q) + (ProdW+1)'(p_ir_q) + (ProdW+1)'(1 <<< (TwFrac - 1));
    tr    = sum_r[ProdW:TwFrac];
    ti    = sum_i[ProdW:TwFrac];
    vr    = rdata1[2*BinW-1:BinW];
    vi    = rdata1[BinW-1:0];
  end

  // Memory ports, command pop and result push.
  always_comb begin
    we          = 1'b0;
    waddr       = addr_a;
    wdata       = a_val_q;
    raddr0      = addr_a;
    raddr1      = addr_b;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_re_o    = '0;
    res_im_o    = '0;
    res_index_o = '0;
    res_last_o  = 1'b0;
    res_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        raddr0 = read_cnt_q;
        if (cmd_valid_i && !cmd_i) begin
          cmd_pop_o = 1'b1;
          we        = 1'b1;
          waddr     = rev_addr;
          wdata     = {BinW'(re_i), BinW'(im_i)};
        end else if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o  = 1'b1;
          res_push_o = !done_q;
        end
      end
      ST_RD: begin
        res_push_o  = 1'b1;
        res_re_o    = rdata0[2*BinW-1:BinW];
        res_im_o    = rdata0[BinW-1:0];
        res_index_o = read_cnt_q;
        res_last_o  = (read_cnt_q == Log'(POINTS - 1));
        res_ready_o = 1'b1;
      end
      ST_BF_WA: we = 1'b1;
      ST_BF_WB: begin
        we    = 1'b1;
        waddr = addr_b;
        wdata = b_val_q;
      end
      default: ;
    endcase
  end

  r2fft_ram #(.WIDTH(2 * BinW), .DEPTH(POINTS)) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  // Sequencer: one item at a time; each butterfly steps through the read, multiply, add and two write states.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      load_cnt_q <= '0;
      read_cnt_q <= '0;
      done_q     <= 1'b0;
      stage_q    <= '0;
      bf_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i && !cmd_i) begin
            if (load_cnt_q == '0) done_q <= 1'b0;
            if (load_cnt_q == Log'(POINTS - 1)) begin
              load_cnt_q <= '0;
              read_cnt_q <= '0;
              stage_q    <= '0;
              bf_q       <= '0;
              state_q    <= ST_BF_RD;
            end else begin
              load_cnt_q <= load_cnt_q + 1'b1;
            end
          end else if (cmd_valid_i && !res_full_i && done_q) begin
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          read_cnt_q <= read_cnt_q + 1'b1;
          state_q    <= ST_IDLE;
        end
        ST_BF_RD:  state_q <= ST_BF_MUL;
        ST_BF_MUL: state_q <= ST_BF_ADD;
        ST_BF_ADD: state_q <= ST_BF_WA;
        ST_BF_WA:  state_q <= ST_BF_WB;
        ST_BF_WB: begin
          if (last_bf) begin
            bf_q <= '0;
            if (stage_q == StgW'(Log - 1)) begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              stage_q <= stage_q + 1'b1;
              state_q <= ST_BF_RD;
            end
          end else begin
            bf_q    <= bf_q + 1'b1;
            state_q <= ST_BF_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers of the butterfly.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_BF_MUL) begin
      ur_q   <= rdata0[2*BinW-1:BinW];
      ui_q   <= rdata0[BinW-1:0];
      p_rr_q <= ProdW'(vr) * ProdW'(wr);
      p_ii_q <= ProdW'(vi) * ProdW'(wi);
      p_ri_q <= ProdW'(vr) * ProdW'(wi);
      p_ir_q <= ProdW'(vi) * ProdW'(wr);
    end
    if (state_q == ST_BF_ADD) begin
      a_val_q <= {sat_fn(SumW'(ur_q) + SumW'(tr)), sat_fn(SumW'(ui_q) + SumW'(ti))};
      b_val_q <= {sat_fn(SumW'(ur_q) - SumW'(tr)), sat_fn(SumW'(ui_q) - SumW'(ti))};
    end
  end

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i) else $error("result pushed into a full queue");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == ST_IDLE)) else $error("command taken while busy");
  a_frame_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BF_WB && last_bf && stage_q == StgW'(Log - 1)) |=> done_q)
    else $error("transform finished without marking the frame done");
  a_rd_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> done_q) else $error("bin read without a frame");
`endif

endmodule

// File: rtl/radix2_complex_fft.sv
// Top level of the radix-2 complex FFT: command queue, core and result queue.
//
//  channel  | handshake      | fields
//  ---------+----------------+---------------------------------------------
//  command  | push_i, full_o | cmd_i, sample_re_i, sample_im_i
//  result   | pop_i, empty_o | bin_re_o, bin_im_o, bin_index_o, last_bin_o,
//           |                | ready_res_o
//
// A load writes its sample straight into the frame store; the load that ends a
// frame starts the transform, which runs one shared butterfly unit, with the
// frame store's single write port setting the pace. A bin read goes through
// the registered store read.
// Reset clears the counters and the frame flag; the store holds no reset value.
// The two-entry queues on each side let the feeder and the consumer stall freely.
module radix2_complex_fft #(
  parameter int POINTS      = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         push_i,
  output logic                                         full_o,
  input  logic                                         cmd_i,
  input  logic signed [SAMPLE_BITS-1:0]                sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0]                sample_im_i,
  output logic                                         empty_o,
  input  logic                                         pop_i,
  output logic signed [SAMPLE_BITS+$clog2(POINTS)+1:0] bin_re_o,
  output logic signed [SAMPLE_BITS+$clog2(POINTS)+1:0] bin_im_o,
  output logic [$clog2(POINTS)-1:0]                    bin_index_o,
  output logic                                         last_bin_o,
  output logic                                         ready_res_o
);

  localparam int Log  = $clog2(POINTS);
  localparam int BinW = SAMPLE_BITS + Log + 2;
  localparam int CmdW = 1 + 2 * SAMPLE_BITS;
  localparam int ResW = 2 * BinW + Log + 2;

  logic                          cmd_empty, cmd_pop, cmd_bit;
  logic [CmdW-1:0]               cmd_word;
  logic signed [SAMPLE_BITS-1:0] c_re, c_im;
  logic                          res_full, res_push, r_last, r_ready;
  logic signed [BinW-1:0]        r_re, r_im;
  logic [Log-1:0]                r_idx;
  logic [ResW-1:0]               res_word;

  // Front: command queue.
  r2fft_fifo #(.WIDTH(CmdW), .DEPTH(2)) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i ({cmd_i, sample_re_i, sample_im_i}),
    .full_o  (full_o),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_word),
    .empty_o (cmd_empty)
  );

  assign {cmd_bit, c_re, c_im} = cmd_word;

  // Back: transform engine.
  r2fft_core #(.POINTS(POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_bit),
    .re_i        (c_re),
    .im_i        (c_im),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_re_o    (r_re),
    .res_im_o    (r_im),
    .res_index_o (r_idx),
    .res_last_o  (r_last),
    .res_ready_o (r_ready)
  );

  // Result queue.
  r2fft_fifo #(.WIDTH(ResW), .DEPTH(2)) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i ({r_re, r_im, r_idx, r_last, r_ready}),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (res_word),
    .empty_o (empty_o)
  );

  assign {bin_re_o, bin_im_o, bin_index_o, last_bin_o, ready_res_o} = res_word;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the radix-2 complex FFT: random frames, bin reads and stalls.
module tb_top;
  import r2fft_pkg::*;

  localparam int Points     = 64;
  localparam int SampleBits = 16;
  localparam int LogPts     = $clog2(Points);
  localparam int BinW       = SampleBits + LogPts + 2;
  localparam longint SatLim = longint'(1) << (SampleBits + LogPts);
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 40;

  typedef enum logic {CmdLoad = 1'b0, CmdRead = 1'b1} cmd_e;

  typedef struct packed {
    logic signed [BinW-1:0] re;
    logic signed [BinW-1:0] im;
    logic [LogPts-1:0]      index;
    logic                   last;
    logic                   ready;
  } bin_t;

  // Predicts the bins of the in-place transform and holds the bins still owed.
  class fft_bin_predictor;
    longint frame_re[Points];
    longint frame_im[Points];
    longint tw_re[Points/2];
    longint tw_im[Points/2];
    int     load_count;
    int     read_count;
    bit     frame_done;
    bin_t   expected_bins[$];
    int     mismatches;

    function new();
      real    unit;
      longint cv;
      longint sv;
      int     m;
      unit = 2.0 * 3.14159265358979323846 / Points;
      // Twiddles rounded half up to Q1.17; the second quarter reuses the first.
      for (int k = 0; k < Points / 2; k++) begin
        m  = (k < Points / 4) ? k : k - Points / 4;
        cv = longint'($floor($cos(unit * m) * 131072.0 + 0.5));
        sv = longint'($floor($sin(unit * m) * 131072.0 + 0.5));
        if (cv < 0) cv = 0;
        if (sv < 0) sv = 0;
        if (k < Points / 4) begin
          tw_re[k] = cv;
          tw_im[k] = -sv;
        end else begin
          tw_re[k] = -sv;
          tw_im[k] = -cv;
        end
      end
      load_count = 0;
      read_count = 0;
      frame_done = 0;
      mismatches = 0;
    endfunction

    function longint clip(longint v);
      if (v > SatLim) return SatLim;
      if (v < -SatLim) return -SatLim;
      return v;
    endfunction

    function int reverse_bits(int v);
      int r;
      r = 0;
      for (int b = 0; b < LogPts; b++) r |= ((v >> b) & 1) << (LogPts - 1 - b);
      return r;
    endfunction

    function void run_transform();
      int     j;
      int     half;
      int     step;
      int     a;
      int     b;
      longint t;
      longint tr;
      longint ti;
      longint ur;
      longint ui;
      // Bit-reversal permutation, then the butterfly stages without scaling.
      for (int i = 0; i < Points; i++) begin
        j = reverse_bits(i);
        if (i < j) begin
          t = frame_re[i]; frame_re[i] = frame_re[j]; frame_re[j] = t;
          t = frame_im[i]; frame_im[i] = frame_im[j]; frame_im[j] = t;
        end
      end
      for (int len = 2; len <= Points; len *= 2) begin
        half = len / 2;
        step = Points / len;
        for (int i = 0; i < Points; i += len) begin
          for (int k = 0; k < half; k++) begin
            a  = i + k;
            b  = a + half;
            j  = (k * step) % (Points / 2);
            tr = (frame_re[b] * tw_re[j] - frame_im[b] * tw_im[j] + (64'sd1 << 16)) >>> TwFrac;
            ti = (frame_re[b] * tw_im[j] + frame_im[b] * tw_re[j] + (64'sd1 << 16)) >>> TwFrac;
            ur = frame_re[a];
            ui = frame_im[a];
            frame_re[a] = clip(ur + tr);
            frame_im[a] = clip(ui + ti);
            frame_re[b] = clip(ur - tr);
            frame_im[b] = clip(ui - ti);
          end
        end
      end
    endfunction

    // Notes one accepted command and queues the bin that a read returns.
    function void note_command(cmd_e c, logic signed [SampleBits-1:0] re,
                               logic signed [SampleBits-1:0] im);
      bin_t e;
      if (c == CmdLoad) begin
        if (load_count == 0) frame_done = 0;
        frame_re[load_count] = re;
        frame_im[load_count] = im;
        load_count++;
        if (load_count == Points) begin
          run_transform();
          load_count = 0;
          read_count = 0;
          frame_done = 1;
        end
      end else begin
        e = '0;
        if (frame_done) begin
          e.re    = BinW'(clip(frame_re[read_count]));
          e.im    = BinW'(clip(frame_im[read_count]));
          e.index = LogPts'(read_count);
          e.last  = (read_count == Points - 1);
          e.ready = 1'b1;
          read_count = (read_count + 1) % Points;
        end
        expected_bins.push_back(e);
      end
    endfunction

    // Compares one popped bin against the oldest expected bin.
    function void check_bin(bin_t got);
      bin_t e;
      if (expected_bins.size() == 0) begin
        $error("unexpected bin popped: re=%0d im=%0d", got.re, got.im);
        mismatches++;
        return;
      end
      e = expected_bins.pop_front();
      if (got.re !== e.re) begin
        $error("bin_re: expected %0d, actual %0d", e.re, got.re); mismatches++;
      end
      if (got.im !== e.im) begin
        $error("bin_im: expected %0d, actual %0d", e.im, got.im); mismatches++;
      end
      if (got.index !== e.index) begin
        $error("bin_index: expected %0d, actual %0d", e.index, got.index); mismatches++;
      end
      if (got.last !== e.last) begin
        $error("last_bin: expected %0d, actual %0d", e.last, got.last); mismatches++;
      end
      if (got.ready !== e.ready) begin
        $error("ready_res: expected %0d, actual %0d", e.ready, got.ready); mismatches++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          push_i;
  logic                          full_o;
  logic                          cmd_i;
  logic signed [SampleBits-1:0]  sample_re_i;
  logic signed [SampleBits-1:0]  sample_im_i;
  logic                          empty_o;
  logic                          pop_i;
  logic signed [BinW-1:0]        bin_re_o;
  logic signed [BinW-1:0]        bin_im_o;
  logic [LogPts-1:0]             bin_index_o;
  logic                          last_bin_o;
  logic                          ready_res_o;

  fft_bin_predictor predictor;
  int  cycle_count;
  bit  push_burst;
  bit  pop_burst;

  radix2_complex_fft #(
    .POINTS     (Points),
    .SAMPLE_BITS(SampleBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .cmd_i      (cmd_i),
    .sample_re_i(sample_re_i),
    .sample_im_i(sample_im_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .bin_re_o   (bin_re_o),
    .bin_im_o   (bin_im_o),
    .bin_index_o(bin_index_o),
    .last_bin_o (last_bin_o),
    .ready_res_o(ready_res_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Cycle counter with a timeout.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drives one command and waits until the block takes it.
  task automatic send_item(cmd_e c, logic signed [SampleBits-1:0] re,
                           logic signed [SampleBits-1:0] im);
    int gap;
    if ($urandom_range(0, 59) == 0) push_burst = ~push_burst;
    gap = push_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i      <= 1'b1;
    cmd_i       <= c;
    sample_re_i <= re;
    sample_im_i <= im;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    predictor.note_command(c, re, im);
  endtask

  // Loads n samples, full-range or small at random.
  task automatic load_samples(int n);
    bit wide;
    wide = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      if (wide) send_item(CmdLoad, SampleBits'($urandom), SampleBits'($urandom));
      else send_item(CmdLoad, SampleBits'(int'($urandom_range(0, 511)) - 256),
                     SampleBits'(int'($urandom_range(0, 511)) - 256));
    end
  endtask

  // Pops results with random stalls and checks each one.
  initial begin
    int   gap;
    bin_t got;
    pop_i = 1'b0;
    pop_burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 59) == 0) pop_burst = ~pop_burst;
      gap = pop_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        pop_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop_i <= 1'b1;
      @(posedge clk_i);
      while (empty_o) @(posedge clk_i);
      got = '{bin_re_o, bin_im_o, bin_index_o, last_bin_o, ready_res_o};
      predictor.check_bin(got);
    end
  end

  // Stimulus and end of run.
  initial begin
    int sent;
    predictor   = new();
    push_burst  = 1'b0;
    rst_ni      = 1'b0;
    push_i      = 1'b0;
    cmd_i       = CmdLoad;
    sample_re_i = '0;
    sample_im_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reads before any frame return zeros with ready low.
    send_item(CmdRead, '0, '0);
    send_item(CmdRead, '0, '0);
    // A frame of extreme values, then the first four bins.
    for (int i = 0; i < Points; i++) begin
      send_item(CmdLoad, (i % 3 == 0) ? 16'sh7fff : 16'sh8000,
                (i % 2 == 0) ? 16'sh8000 : 16'sh7fff);
    end
    for (int i = 0; i < 4; i++) send_item(CmdRead, '0, '0);
    // Load of a new frame drops the held transform.
    send_item(CmdLoad, 16'sh7fff, 16'sh8000);
    send_item(CmdRead, '0, '0);
    load_samples(Points - 1);
    for (int i = 0; i < Points + 3; i++) send_item(CmdRead, '0, '0);

    // Random frames with reads, wraps and interrupted frames.
    sent = 0;
    while (sent < 2000) begin
      if ($urandom_range(0, 7) == 0) begin
        send_item(CmdLoad, SampleBits'($urandom), SampleBits'($urandom));
        sent++;
      end else if ($urandom_range(0, 9) == 0) begin
        send_item(CmdRead, SampleBits'($urandom), SampleBits'($urandom));
        sent++;
      end else begin
        load_samples(Points - predictor.load_count);
        sent += Points;
        for (int r = $urandom_range(0, 80); r > 0; r--) begin
          send_item(CmdRead, SampleBits'($urandom), SampleBits'($urandom));
          sent++;
        end
      end
    end
    push_i <= 1'b0;

    while (predictor.expected_bins.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (predictor.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
